// ===== hw/rtl/mtbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtbp_pkg
// Shared types, codes and character classes for the media-type byte parser.
// ----------------------------------------------------------------------------
package mtbp_pkg;

	localparam int unsigned QLEN_W       = 16;
	localparam int unsigned ERR_W        = 4;
	localparam int unsigned ROLE_W       = 3;
	localparam logic [QLEN_W-1:0] QLEN_RESET = QLEN_W'(4 * 1024);
	localparam logic [QLEN_W-1:0] QLEN_SAT   = '1;

	typedef enum logic [3:0] {
		PH_LEAD       = 4'd0,
		PH_TYPE       = 4'd1,
		PH_TYPE_TRAIL = 4'd2,
		PH_NAME_WAIT  = 4'd3,
		PH_NAME       = 4'd4,
		PH_EQ_WAIT    = 4'd5,
		PH_VAL_WAIT   = 4'd6,
		PH_TOKVAL     = 4'd7,
		PH_QUOTED     = 4'd8,
		PH_ESC        = 4'd9,
		PH_SEP        = 4'd10
	} phase_t;

	typedef enum logic [ROLE_W-1:0] {
		ROLE_DROP  = 3'd0,
		ROLE_MAJOR = 3'd1,
		ROLE_SLASH = 3'd2,
		ROLE_SUB   = 3'd3,
		ROLE_NAME  = 3'd4,
		ROLE_VALUE = 3'd5
	} role_t;

	localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
	localparam logic [ERR_W-1:0] ERR_TYPE      = 4'd1;
	localparam logic [ERR_W-1:0] ERR_SEP       = 4'd2;
	localparam logic [ERR_W-1:0] ERR_NAME      = 4'd3;
	localparam logic [ERR_W-1:0] ERR_EQUALS    = 4'd4;
	localparam logic [ERR_W-1:0] ERR_VALUE     = 4'd5;
	localparam logic [ERR_W-1:0] ERR_DANGLING  = 4'd6;
	localparam logic [ERR_W-1:0] ERR_ESCAPED   = 4'd7;
	localparam logic [ERR_W-1:0] ERR_QUOTED    = 4'd8;
	localparam logic [ERR_W-1:0] ERR_QUOTE_LEN = 4'd9;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HTAB   = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_HIGH   = 8'h80;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// parser state carried between words
	typedef struct packed {
		phase_t            phase;
		logic [ERR_W-1:0]  err;
		logic [QLEN_W-1:0] qoff;
		logic              slash;
		logic              nonempty;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase: PH_LEAD, err: ERR_NONE, qoff: '0, slash: 1'b0, nonempty: 1'b0
	};

	// result of one byte
	typedef struct packed {
		logic [7:0]       data;
		role_t            role;
		logic             start;
		logic [ERR_W-1:0] code;
	} tag_t;

	function automatic logic is_special(input logic [7:0] c);
		return c == 8'h28 || c == 8'h29 || c == 8'h3C || c == 8'h3E || c == 8'h40
			|| c == 8'h2C || c == 8'h3B || c == 8'h3A || c == 8'h5C || c == 8'h22
			|| c == 8'h2F || c == 8'h5B || c == 8'h5D || c == 8'h3F || c == 8'h3D;
	endfunction

	function automatic logic is_tok(input logic [7:0] c);
		return c > CH_SPACE && c < CH_DEL && !is_special(c);
	endfunction

	function automatic logic is_trim(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_HTAB && c <= CH_CR);
	endfunction

	function automatic logic is_pair(input logic [7:0] c);
		return c == CH_HTAB || c == CH_SPACE || (c > CH_SPACE && c < CH_DEL)
			|| c >= CH_HIGH;
	endfunction

	function automatic logic is_qdtext(input logic [7:0] c);
		return c == CH_HTAB || c == CH_SPACE || c == 8'h21
			|| (c >= 8'h23 && c <= 8'h5B) || (c >= 8'h5D && c <= 8'h7E)
			|| c >= CH_HIGH;
	endfunction

	function automatic logic [7:0] ascii_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

endpackage

// ===== hw/rtl/media_type_byte_parser.sv =====
// ----------------------------------------------------------------------------
// media_type_byte_parser
// Tags each octet of a media-type header as type, slash, subtype, parameter
// name, parameter value or dropped, and reports the first error at the end.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the header text on the s_axis side, one octet per word, with
//   s_axis_tlast on the final octet. Every input word yields exactly one
//   output word on m_axis: the passed octet and, on the tlast word, the
//   sticky error code. tuser carries the role and the part-start flag.
//   cfg_we/cfg_data set the quoted-string length limit (reset 4096); write it
//   only while no word is in flight.
// Timing:
//   A word is held in one input register, then passes through the phase
//   logic into the result register. Throughput is one word per cycle
//   while m_axis_tready stays high; the phase register closes its loop
//   through combinational step logic only.
// Reset:
//   arst_n clears both stages and returns the parser to the start of a header.
//   The parser also rewinds by itself after every tlast word.
// Backpressure:
//   When m_axis_tready is low the result register holds; the input register
//   still fills once, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module media_type_byte_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [mtbp_pkg::QLEN_W-1:0] cfg_data,   // max_quoted_len
	// input stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
	input  logic                        s_axis_tlast,   // last_byte
	// output stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [15:0]                 m_axis_tdata,   // [7:0] out_byte,
	                                                    // [11:8] error_code, rest 0
	output logic [3:0]                  m_axis_tuser,   // [2:0] byte_role, [3] part_start
	output logic                        m_axis_tlast    // finished
);
	import mtbp_pkg::*;

	// configuration register
	logic [QLEN_W-1:0] max_len_q;

	// stage 1: raw input word
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// stage 2: tagged result word
	logic       valid_s2;
	tag_t       tag_s2;
	logic       last_s2;

	// parser state, advanced as each word moves from stage 1 to stage 2
	parse_state_t state_q;
	parse_state_t state_nxt;
	tag_t         tag_nxt;

	logic advance;

	// move a word forward when the result register is free or being emptied
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= QLEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	// input register: load on accept, drop when handed on with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	mtbp_step u_step (
		.cur     (state_q),
		.c       (byte_s1),
		.last    (last_s1),
		.max_len (max_len_q),
		.nxt     (state_nxt),
		.tag     (tag_nxt)
	);

	// parser state steps once per word that leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s2  <= tag_nxt;
			last_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, tag_s2.code, tag_s2.data};
	assign m_axis_tuser  = {tag_s2.start, tag_s2.role};
	assign m_axis_tlast  = last_s2;

endmodule

// ===== hw/rtl/mtbp_step.sv =====
// ----------------------------------------------------------------------------
// mtbp_step
// Per-byte phase transition and tagging, purely combinational.
// ----------------------------------------------------------------------------
module mtbp_step (
	input  mtbp_pkg::parse_state_t        cur,
	input  logic [7:0]                    c,
	input  logic                          last,
	input  logic [mtbp_pkg::QLEN_W-1:0]   max_len,
	output mtbp_pkg::parse_state_t        nxt,
	output mtbp_pkg::tag_t                tag
);
	import mtbp_pkg::*;

	parse_state_t     st;
	logic [7:0]       ob;
	role_t            role;
	logic             ps;
	logic [ERR_W-1:0] err;
	logic [QLEN_W-1:0] qinc;

	assign qinc = (cur.qoff != QLEN_SAT) ? cur.qoff + 1'b1 : cur.qoff;

	always_comb begin
		st   = cur;
		ob   = '0;
		role = ROLE_DROP;
		ps   = 1'b0;
		err  = ERR_NONE;

		if (cur.err == ERR_NONE) begin
			unique case (cur.phase)
				PH_LEAD: begin
					if (is_trim(c)) begin
					end else if (is_tok(c)) begin
						role = ROLE_MAJOR; ob = ascii_lower(c); st.nonempty = 1'b1;
						st.phase = PH_TYPE;
					end else begin
						err = ERR_TYPE;
					end
				end
				PH_TYPE: begin
					if (is_tok(c)) begin
						role = cur.slash ? ROLE_SUB : ROLE_MAJOR;
						ob = ascii_lower(c); st.nonempty = 1'b1;
					end else if (c == CH_SLASH) begin
						if (cur.slash) begin
							err = ERR_TYPE;
						end else begin
							st.slash = 1'b1; st.nonempty = 1'b0;
							role = ROLE_SLASH; ob = c;
						end
					end else if (is_trim(c)) begin
						st.phase = PH_TYPE_TRAIL;
					end else if (c == CH_SEMI) begin
						if (cur.slash && !cur.nonempty) err = ERR_TYPE;
						else st.phase = PH_NAME_WAIT;
					end else begin
						err = ERR_TYPE;
					end
				end
				PH_TYPE_TRAIL: begin
					if (is_trim(c)) begin
					end else if (c == CH_SEMI && !(cur.slash && !cur.nonempty)) begin
						st.phase = PH_NAME_WAIT;
					end else begin
						err = ERR_TYPE;
					end
				end
				PH_NAME_WAIT: begin
					if (c == CH_SPACE || c == CH_SEMI) begin
					end else if (is_tok(c)) begin
						role = ROLE_NAME; ob = ascii_lower(c); ps = 1'b1;
						st.phase = PH_NAME;
					end else begin
						err = ERR_NAME;
					end
				end
				PH_NAME: begin
					if (is_tok(c)) begin
						role = ROLE_NAME; ob = ascii_lower(c);
					end else if (c == CH_SPACE) begin
						st.phase = PH_EQ_WAIT;
					end else if (c == CH_EQUALS) begin
						st.phase = PH_VAL_WAIT;
					end else begin
						err = ERR_EQUALS;
					end
				end
				PH_EQ_WAIT: begin
					if (c == CH_SPACE) begin
					end else if (c == CH_EQUALS) begin
						st.phase = PH_VAL_WAIT;
					end else begin
						err = ERR_EQUALS;
					end
				end
				PH_VAL_WAIT: begin
					if (c == CH_SPACE) begin
					end else if (c == CH_DQUOTE) begin
						st.qoff = QLEN_W'(1); st.nonempty = 1'b0; st.phase = PH_QUOTED;
					end else if (is_tok(c)) begin
						role = ROLE_VALUE; ob = c; ps = 1'b1; st.phase = PH_TOKVAL;
					end else begin
						err = ERR_VALUE;
					end
				end
				PH_TOKVAL: begin
					if (is_tok(c)) begin
						role = ROLE_VALUE; ob = c;
					end else if (c == CH_SPACE) begin
						st.phase = PH_SEP;
					end else if (c == CH_SEMI) begin
						st.phase = PH_NAME_WAIT;
					end else begin
						err = ERR_SEP;
					end
				end
				PH_QUOTED: begin
					if (cur.qoff >= max_len) begin
						err = ERR_QUOTE_LEN;
					end else if (c == CH_DQUOTE) begin
						st.phase = PH_SEP;
					end else if (c == CH_BSLASH) begin
						st.qoff = qinc; st.phase = PH_ESC;
					end else if (is_qdtext(c)) begin
						role = ROLE_VALUE; ob = c; ps = !cur.nonempty;
						st.nonempty = 1'b1; st.qoff = qinc;
					end else begin
						err = ERR_QUOTED;
					end
				end
				PH_ESC: begin
					if (is_pair(c)) begin
						role = ROLE_VALUE; ob = c; ps = !cur.nonempty;
						st.nonempty = 1'b1; st.qoff = qinc; st.phase = PH_QUOTED;
					end else begin
						err = ERR_ESCAPED;
					end
				end
				PH_SEP: begin
					if (c == CH_SPACE) begin
					end else if (c == CH_SEMI) begin
						st.phase = PH_NAME_WAIT;
					end else begin
						err = ERR_SEP;
					end
				end
				default: err = ERR_TYPE;
			endcase
			if (err != ERR_NONE) begin
				st.err = err; role = ROLE_DROP; ob = '0; ps = 1'b0;
			end
		end

		tag.data  = ob;
		tag.role  = role;
		tag.start = ps;
		tag.code  = ERR_NONE;
		nxt       = st;

		if (last) begin
			if (st.err == ERR_NONE) begin
				unique case (st.phase)
					PH_LEAD, PH_TYPE, PH_TYPE_TRAIL: tag.code = ERR_TYPE;
					PH_NAME, PH_EQ_WAIT:             tag.code = ERR_EQUALS;
					PH_VAL_WAIT:                     tag.code = ERR_VALUE;
					PH_ESC:                          tag.code = ERR_DANGLING;
					default:                         tag.code = ERR_NONE;
				endcase
			end else begin
				tag.code = st.err;
			end
			nxt = PARSE_RESET;
		end
	end

endmodule
